[hw/rtl/cfd_pkg.sv]
// Shared types and constants for the command frame deframer.
package cfd_pkg;

  localparam logic [7:0] CMD_STRING   = 8'h01;
  localparam logic [7:0] CMD_BAUD     = 8'h02;
  localparam logic [7:0] CMD_SHUTDOWN = 8'h03;

  typedef enum logic [1:0] {
    EV_PAYLOAD  = 2'd0,
    EV_CHECK    = 2'd1,
    EV_BAUD     = 2'd2,
    EV_SHUTDOWN = 2'd3
  } event_kind_t;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_LEN     = 3'd1,
    PH_PAYLOAD = 3'd2,
    PH_CHECK   = 3'd3,
    PH_BAUD    = 3'd4,
    PH_HALT    = 3'd5
  } phase_t;

  typedef struct packed {
    logic [1:0]  event_kind;
    logic [7:0]  payload_byte;
    logic        payload_last;
    logic        check_ok;
    logic [31:0] baud_value;
  } result_t;

endpackage

[hw/rtl/cfd_if.sv]
// Channel interfaces: received bytes, result items and the configuration write.
interface cfd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface cfd_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  event_kind;
  logic [7:0]  payload_byte;
  logic        payload_last;
  logic        check_ok;
  logic [31:0] baud_value;
  modport source (output valid, output event_kind, output payload_byte,
                  output payload_last, output check_ok, output baud_value,
                  input ready);
  modport sink (input valid, input event_kind, input payload_byte,
                input payload_last, input check_ok, input baud_value,
                output ready);
endinterface

interface cfd_cfg_if;
  logic valid;
  logic ready;
  logic word_big_endian;
  modport source (output valid, output word_big_endian, input ready);
  modport sink (input valid, input word_big_endian, output ready);
endinterface

[hw/rtl/cfd_parser.sv]
// Frame parser: phase state, word assembly and the result of one received byte.
module cfd_parser (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  logic [7:0]       rx_byte,
  input  logic             word_big_endian,
  output logic             res_valid,
  output cfd_pkg::result_t res
);
  import cfd_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [1:0]  idx_r, idx_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic [30:0] remaining_r, remaining_nxt;
  logic        parity_r, parity_nxt;
  logic [31:0] acc_shift;
  logic        word_done;
  logic        last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      idx_r       <= 2'd0;
      acc_r       <= 32'd0;
      remaining_r <= 31'd0;
      parity_r    <= 1'b0;
    end else if (step) begin
      phase_r     <= phase_nxt;
      idx_r       <= idx_nxt;
      acc_r       <= acc_nxt;
      remaining_r <= remaining_nxt;
      parity_r    <= parity_nxt;
    end
  end

  // Each byte is placed by the byte order in force when it arrives.
  assign acc_shift = word_big_endian ? {acc_r[23:0], rx_byte} : {rx_byte, acc_r[31:8]};
  assign word_done = (idx_r == 2'd3);
  assign last      = (remaining_r <= 31'd1);

  always_comb begin
    phase_nxt     = phase_r;
    idx_nxt       = idx_r;
    acc_nxt       = acc_r;
    remaining_nxt = remaining_r;
    parity_nxt    = parity_r;
    res_valid     = 1'b0;
    res           = '0;
    case (phase_r)
      PH_LEN: begin
        acc_nxt = acc_shift;
        idx_nxt = idx_r + 2'd1;
        if (word_done) begin
          parity_nxt = 1'b0;
          // A zero or negative length goes straight to the check byte.
          if (acc_shift == 32'd0 || acc_shift[31]) begin
            remaining_nxt = 31'd0;
            phase_nxt     = PH_CHECK;
          end else begin
            remaining_nxt = acc_shift[30:0];
            phase_nxt     = PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        parity_nxt       = parity_r | rx_byte[0];
        res_valid        = 1'b1;
        res.event_kind   = EV_PAYLOAD;
        res.payload_byte = rx_byte;
        res.payload_last = last;
        if (last) begin
          remaining_nxt = 31'd0;
          phase_nxt     = PH_CHECK;
        end else begin
          remaining_nxt = remaining_r - 31'd1;
        end
      end
      PH_CHECK: begin
        res_valid      = 1'b1;
        res.event_kind = EV_CHECK;
        res.check_ok   = (rx_byte == {7'd0, parity_r});
        parity_nxt     = 1'b0;
        phase_nxt      = PH_IDLE;
      end
      PH_BAUD: begin
        acc_nxt = acc_shift;
        idx_nxt = idx_r + 2'd1;
        if (word_done) begin
          res_valid      = 1'b1;
          res.event_kind = EV_BAUD;
          res.baud_value = acc_shift;
          phase_nxt      = PH_IDLE;
        end
      end
      PH_HALT: begin
        phase_nxt = PH_HALT;
      end
      default: begin
        case (rx_byte)
          CMD_STRING: begin
            phase_nxt = PH_LEN;
            idx_nxt   = 2'd0;
            acc_nxt   = 32'd0;
          end
          CMD_BAUD: begin
            phase_nxt = PH_BAUD;
            idx_nxt   = 2'd0;
            acc_nxt   = 32'd0;
          end
          CMD_SHUTDOWN: begin
            phase_nxt      = PH_HALT;
            res_valid      = 1'b1;
            res.event_kind = EV_SHUTDOWN;
          end
          default: begin
            phase_nxt = PH_IDLE;
          end
        endcase
      end
    endcase
  end

  a_halt_sticks: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_HALT |=> phase_r == PH_HALT)
    else $error("parser left the halted phase");

  a_idle_word_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_IDLE |-> idx_r == 2'd0)
    else $error("word byte index not zero while waiting for a command");

  a_payload_count: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_PAYLOAD |-> remaining_r != 31'd0)
    else $error("payload phase with no bytes remaining");

endmodule

[hw/rtl/command_frame_deframer_unit.sv]
// Top level of the command frame deframer: byte parser with a two-entry result buffer.
//
//   channel | direction | payload
//   in_ch   | sink      | rx_byte[7:0]
//   out_ch  | source    | event_kind[1:0], payload_byte[7:0], payload_last,
//           |           | check_ok, baud_value[31:0]
//   cfg_ch  | sink      | word_big_endian (always ready)
//
// One byte is taken per cycle while the skid entry is empty; any result is registered.
// The result register plus one skid entry let a byte be accepted while a result waits.
// Input ready drops only when both the result register and the skid entry are full.
// Reset is synchronous on rst_n and returns the parser to waiting for a command byte.
module command_frame_deframer_unit (
  input logic       clk,
  input logic       rst_n,
  cfd_in_if.sink    in_ch,
  cfd_out_if.source out_ch,
  cfd_cfg_if.sink   cfg_ch
);
  import cfd_pkg::*;

  logic    big_endian_r;
  logic    out_valid_r;
  logic    skid_valid_r;
  result_t out_r;
  result_t skid_r;
  logic    step;
  logic    res_valid;
  result_t res;
  logic    pop;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = !skid_valid_r;
  assign step         = in_ch.valid && in_ch.ready;
  assign pop          = out_valid_r && out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      big_endian_r <= 1'b0;
    end else if (cfg_ch.valid) begin
      big_endian_r <= cfg_ch.word_big_endian;
    end
  end

  cfd_parser u_parser (
    .clk             (clk),
    .rst_n           (rst_n),
    .step            (step),
    .rx_byte         (in_ch.rx_byte),
    .word_big_endian (big_endian_r),
    .res_valid       (res_valid),
    .res             (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      // No byte is accepted here, so only the skid entry can move up.
      if (pop) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end
    end else if (step && res_valid) begin
      if (!out_valid_r || pop) begin
        out_valid_r <= 1'b1;
      end else begin
        skid_valid_r <= 1'b1;
      end
    end else if (pop) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (pop) begin
        out_r <= skid_r;
      end
    end else if (step && res_valid) begin
      if (!out_valid_r || pop) begin
        out_r <= res;
      end else begin
        skid_r <= res;
      end
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.event_kind   = out_r.event_kind;
  assign out_ch.payload_byte = out_r.payload_byte;
  assign out_ch.payload_last = out_r.payload_last;
  assign out_ch.check_ok     = out_r.check_ok;
  assign out_ch.baud_value   = out_r.baud_value;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry holds an item while the result register is empty");

  a_stall_to_skid: assert property (@(posedge clk) disable iff (!rst_n)
    (step && res_valid && out_valid_r && !out_ch.ready) |=> skid_valid_r)
    else $error("result produced under stall was not parked in the skid entry");

  a_out_held: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |=> (out_valid_r && $stable(out_r)))
    else $error("result item changed while waiting for the receiver");

endmodule
